// ===== hdl/ccdc_pkg.sv =====
// Shared widths, operation and status codes, and saturation helper for the divergence core.
package ccdc_pkg;

    localparam int CELLS_DEF = 4096;
    localparam int IDX_W     = 13;
    localparam int AREA_W    = 31;
    localparam int VAL_W     = 32;
    localparam int SUM_W     = 50;
    localparam int ATOT_W    = 34;
    localparam int MUL_A_W   = 31;
    localparam int MUL_B_W   = 33;
    localparam int PROD_W    = MUL_A_W + MUL_B_W;
    localparam int DIV_N_W   = 66;
    localparam int DIV_D_W   = 34;

    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_AXIS  = 2'd2;

    localparam logic [1:0] COMP_U = 2'd0;
    localparam logic [1:0] COMP_V = 2'd1;
    localparam logic [1:0] COMP_W = 2'd2;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_AREA = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;

    // Signed 32-bit saturation of a value given as sign and magnitude.
    function automatic logic signed [VAL_W-1:0] sat_mag(input logic neg,
                                                        input logic [DIV_N_W-1:0] mag);
        logic signed [VAL_W-1:0] r;
        if (neg) begin
            if (mag >= DIV_N_W'(64'h8000_0000))
                r = 32'sh8000_0000;
            else
                r = $signed(32'd0 - mag[VAL_W-1:0]);
        end
        else begin
            if (mag > DIV_N_W'(64'h7FFF_FFFF))
                r = 32'sh7FFF_FFFF;
            else
                r = $signed(mag[VAL_W-1:0]);
        end
        return r;
    endfunction

endpackage

// ===== hdl/ccdc_mul.sv =====
// Bit-serial unsigned shift-add multiplier, one multiplier bit per cycle.
module ccdc_mul
    import ccdc_pkg::*;
#(
    parameter int A_W = MUL_A_W,
    parameter int B_W = MUL_B_W
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [A_W-1:0]   a,
    input  logic [B_W-1:0]   b,
    output logic             done,
    output logic [A_W+B_W-1:0] product
);

    localparam int CNT_W = $clog2(B_W + 1);

    logic [A_W+B_W-1:0] acc_reg, acc_next;
    logic [A_W-1:0]     mcand_reg, mcand_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               run_reg, run_next;
    logic               done_reg, done_next;
    logic [A_W:0]       partial;

    always_comb
    begin
        acc_next   = acc_reg;
        mcand_next = mcand_reg;
        cnt_next   = cnt_reg;
        run_next   = run_reg;
        done_next  = 1'b0;
        partial    = {1'b0, acc_reg[A_W+B_W-1:B_W]} +
                     (acc_reg[0] ? {1'b0, mcand_reg} : '0);
        if (start)
        begin
            acc_next   = {{A_W{1'b0}}, b};
            mcand_next = a;
            cnt_next   = '0;
            run_next   = 1'b1;
        end
        else if (run_reg)
        begin
            // The multiplier sits in the low bits and shifts out as the product shifts in.
            acc_next = {partial, acc_reg[B_W-1:1]};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(B_W - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg   <= acc_next;
        mcand_reg <= mcand_next;
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

// ===== hdl/ccdc_div.sv =====
// Restoring unsigned divider that produces one quotient bit per cycle.
module ccdc_div
    import ccdc_pkg::*;
#(
    parameter int N_W = DIV_N_W,
    parameter int D_W = DIV_D_W
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic [N_W-1:0] num,
    input  logic [D_W-1:0] den,
    output logic           done,
    output logic [N_W-1:0] quot
);

    localparam int CNT_W = $clog2(N_W + 1);

    logic [N_W-1:0]   quo_reg, quo_next;
    logic [D_W-1:0]   rem_reg, rem_next;
    logic [D_W-1:0]   den_reg, den_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             run_reg, run_next;
    logic             done_reg, done_next;
    logic [D_W:0]     trial;
    logic [D_W:0]     diff;

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        trial     = {rem_reg, quo_reg[N_W-1]};
        diff      = trial - {1'b0, den_reg};
        if (start)
        begin
            quo_next = num;
            rem_next = '0;
            den_next = den;
            cnt_next = '0;
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            if (trial >= {1'b0, den_reg})
            begin
                rem_next = diff[D_W-1:0];
                quo_next = {quo_reg[N_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[D_W-1:0];
                quo_next = {quo_reg[N_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(N_W - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign done = done_reg;
    assign quot = quo_reg;

endmodule

// ===== hdl/cut_cell_divergence_correction_core.sv =====
// Top level of the cut-cell divergence correction core: stores, sequencer and serial arithmetic.
//
// A request is taken on a rising edge with start high and busy low. operation selects a
// velocity write, a velocity read or one axis part (x, y, z) of a correction stencil.
// Results appear for one cycle with done high and cannot be held off by the receiver;
// the core never waits on the output side.
// A write gives no result. A read result passes through the store read register and the read
// state before it appears with done. An x or y axis request reads two cells and runs one
// serial multiply while busy stays high. A z request does the same, then, unless the area
// sum or a face divisor is zero, one division by the area sum and, for each of the six cells
// in range, a multiply, a division and a read-modify-write; its result carries the status.
// Requests share the one bit-serial multiplier and restoring divider and are handled one
// at a time.
// Reset clears the sequencer, the axis phase, done and status, but not the pending stencil;
// the velocity stores keep no reset and must be written before they are read.
module cut_cell_divergence_correction_core
    import ccdc_pkg::*;
#(
    parameter int CELLS = CELLS_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [1:0]               operation,
    input  logic [1:0]               component,
    input  logic [IDX_W-1:0]         index_a,
    input  logic [IDX_W-1:0]         index_b,
    input  logic [AREA_W-1:0]        area_a,
    input  logic [AREA_W-1:0]        area_b,
    input  logic [AREA_W-1:0]        face_divisor,
    input  logic signed [VAL_W-1:0]  bias,
    input  logic signed [VAL_W-1:0]  write_value,
    output logic                     done,
    output logic signed [VAL_W-1:0]  read_value,
    output logic [1:0]               status
);

    localparam int AW = $clog2(CELLS);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_RD       = 4'd1;
    localparam logic [3:0] S_AX_RB    = 4'd2;
    localparam logic [3:0] S_AX_DIFF  = 4'd3;
    localparam logic [3:0] S_AX_MUL   = 4'd4;
    localparam logic [3:0] S_CHECK    = 4'd5;
    localparam logic [3:0] S_DV_DIV   = 4'd6;
    localparam logic [3:0] S_SH_START = 4'd7;
    localparam logic [3:0] S_SH_MUL   = 4'd8;
    localparam logic [3:0] S_SH_DIV   = 4'd9;
    localparam logic [3:0] S_SH_RD    = 4'd10;
    localparam logic [3:0] S_SH_WR    = 4'd11;

    function automatic logic cell_ok(input logic [IDX_W-1:0] idx);
        return (idx != '0) && (32'(idx) <= 32'(CELLS));
    endfunction

    function automatic logic [AW-1:0] cell_addr(input logic [IDX_W-1:0] idx);
        logic [31:0] t;
        t = 32'(idx) - 32'd1;
        return t[AW-1:0];
    endfunction

    logic [VAL_W-1:0] u_mem [CELLS];
    logic [VAL_W-1:0] v_mem [CELLS];
    logic [VAL_W-1:0] w_mem [CELLS];
    logic [VAL_W-1:0] u_rd_reg, v_rd_reg, w_rd_reg;

    logic [3:0]               state_reg, state_next;
    logic [1:0]               phase_reg, phase_next;
    logic [1:0]               comp_reg, comp_next;
    logic                     rd_ok_reg, rd_ok_next;
    logic signed [VAL_W-1:0]  bias_reg, bias_next;
    logic [IDX_W-1:0]         pidx_reg [6];
    logic [IDX_W-1:0]         pidx_next [6];
    logic [AREA_W-1:0]        parea_reg [6];
    logic [AREA_W-1:0]        parea_next [6];
    logic [AREA_W-1:0]        pdiv_reg [3];
    logic [AREA_W-1:0]        pdiv_next [3];
    logic signed [VAL_W-1:0]  va_reg, va_next;
    logic                     diff_neg_reg, diff_neg_next;
    logic signed [SUM_W-1:0]  sum_reg, sum_next;
    logic [ATOT_W-1:0]        area_reg, area_next;
    logic                     dv_neg_reg, dv_neg_next;
    logic [VAL_W-1:0]         dv_mag_reg, dv_mag_next;
    logic signed [VAL_W-1:0]  share_reg, share_next;
    logic [2:0]               k_reg, k_next;
    logic                     done_reg, done_next;
    logic signed [VAL_W-1:0]  read_value_reg, read_value_next;
    logic [1:0]               status_reg, status_next;

    logic                     mem_we;
    logic [1:0]               mem_wsel;
    logic [AW-1:0]            mem_waddr;
    logic [VAL_W-1:0]         mem_wdata;
    logic [AW-1:0]            mem_raddr;
    logic [1:0]               rsel;
    logic [VAL_W-1:0]         rdata;

    logic                     mul_start, mul_done;
    logic [MUL_A_W-1:0]       mul_a;
    logic [MUL_B_W-1:0]       mul_b;
    logic [PROD_W-1:0]        mul_product;
    logic                     div_start, div_done;
    logic [DIV_N_W-1:0]       div_num;
    logic [DIV_D_W-1:0]       div_den;
    logic [DIV_N_W-1:0]       div_quot;

    logic [2:0]               slot_a;
    logic                     axis_ok;
    logic signed [VAL_W-1:0]  vb;
    logic signed [VAL_W:0]    diff;
    logic [VAL_W:0]           diff_mag;
    logic signed [SUM_W-1:0]  term;
    logic [SUM_W-1:0]         sum_mag;
    logic signed [VAL_W-1:0]  dv;
    logic signed [VAL_W+1:0]  nv;
    logic signed [VAL_W-1:0]  nv_sat;

    ccdc_mul #(.A_W(MUL_A_W), .B_W(MUL_B_W)) u_mul
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .done    (mul_done),
        .product (mul_product)
    );

    ccdc_div #(.N_W(DIV_N_W), .D_W(DIV_D_W)) u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quot  (div_quot)
    );

    always_ff @(posedge clk)
    begin
        if (mem_we && mem_wsel == COMP_U)
            u_mem[mem_waddr] <= mem_wdata;
        if (mem_we && mem_wsel == COMP_V)
            v_mem[mem_waddr] <= mem_wdata;
        if (mem_we && mem_wsel == COMP_W)
            w_mem[mem_waddr] <= mem_wdata;
        u_rd_reg <= u_mem[mem_raddr];
        v_rd_reg <= v_mem[mem_raddr];
        w_rd_reg <= w_mem[mem_raddr];
    end

    always_comb
    begin
        case (rsel)
            COMP_U:  rdata = u_rd_reg;
            COMP_V:  rdata = v_rd_reg;
            COMP_W:  rdata = w_rd_reg;
            default: rdata = '0;
        endcase
    end

    assign slot_a  = {comp_reg, 1'b0};
    assign axis_ok = (component == COMP_U) ||
                     (component == COMP_V && phase_reg == 2'd1) ||
                     (component == COMP_W && phase_reg == 2'd2);

    always_comb
    begin
        state_next      = state_reg;
        phase_next      = phase_reg;
        comp_next       = comp_reg;
        rd_ok_next      = rd_ok_reg;
        bias_next       = bias_reg;
        pidx_next       = pidx_reg;
        parea_next      = parea_reg;
        pdiv_next       = pdiv_reg;
        va_next         = va_reg;
        diff_neg_next   = diff_neg_reg;
        sum_next        = sum_reg;
        area_next       = area_reg;
        dv_neg_next     = dv_neg_reg;
        dv_mag_next     = dv_mag_reg;
        share_next      = share_reg;
        k_next          = k_reg;
        done_next       = 1'b0;
        read_value_next = read_value_reg;
        status_next     = status_reg;

        mem_we    = 1'b0;
        mem_wsel  = component;
        mem_waddr = cell_addr(index_a);
        mem_wdata = write_value;
        mem_raddr = cell_addr(pidx_reg[slot_a]);
        rsel      = comp_reg;

        mul_start = 1'b0;
        mul_a     = pdiv_reg[comp_reg];
        mul_b     = '0;
        div_start = 1'b0;
        div_num   = '0;
        div_den   = area_reg;

        vb       = cell_ok(pidx_reg[slot_a + 3'd1]) ? $signed(rdata) : '0;
        diff     = $signed({va_reg[VAL_W-1], va_reg}) - $signed({vb[VAL_W-1], vb});
        diff_mag = diff[VAL_W] ? (VAL_W+1)'(-diff) : diff;
        term     = $signed(SUM_W'(mul_product[PROD_W-1:16]));
        if (diff_neg_reg)
            term = -term;
        sum_mag  = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : sum_reg;
        dv       = sat_mag(dv_neg_reg, div_quot);
        nv       = k_reg[0] ? ($signed({{2{rdata[VAL_W-1]}}, rdata}) +
                               $signed({{2{share_reg[VAL_W-1]}}, share_reg}))
                            : ($signed({{2{rdata[VAL_W-1]}}, rdata}) -
                               $signed({{2{share_reg[VAL_W-1]}}, share_reg}));
        if (nv > $signed(34'sh0_7FFF_FFFF))
            nv_sat = 32'sh7FFF_FFFF;
        else if (nv < -$signed(34'sh0_8000_0000))
            nv_sat = 32'sh8000_0000;
        else
            nv_sat = nv[VAL_W-1:0];

        case (state_reg)
            S_IDLE:
            begin
                mem_raddr = cell_addr(index_a);
                if (start)
                begin
                    comp_next = component;
                    case (operation)
                        OP_WRITE:
                        begin
                            mem_we = (component != 2'd3) && cell_ok(index_a);
                        end
                        OP_READ:
                        begin
                            rd_ok_next = (component != 2'd3) && cell_ok(index_a);
                            state_next = S_RD;
                        end
                        OP_AXIS:
                        begin
                            if (axis_ok)
                            begin
                                pidx_next[{component, 1'b0}]  = index_a;
                                pidx_next[{component, 1'b1}]  = index_b;
                                parea_next[{component, 1'b0}] = area_a;
                                parea_next[{component, 1'b1}] = area_b;
                                pdiv_next[component]          = face_divisor;
                                bias_next                     = bias;
                                state_next                    = S_AX_RB;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_RD:
            begin
                done_next       = 1'b1;
                read_value_next = rd_ok_reg ? $signed(rdata) : '0;
                status_next     = ST_OK;
                state_next      = S_IDLE;
            end
            S_AX_RB:
            begin
                va_next    = cell_ok(pidx_reg[slot_a]) ? $signed(rdata) : '0;
                mem_raddr  = cell_addr(pidx_reg[slot_a + 3'd1]);
                state_next = S_AX_DIFF;
            end
            S_AX_DIFF:
            begin
                diff_neg_next = diff[VAL_W];
                mul_start     = 1'b1;
                mul_b         = diff_mag;
                state_next    = S_AX_MUL;
            end
            S_AX_MUL:
            begin
                if (mul_done)
                begin
                    if (comp_reg == COMP_U)
                    begin
                        sum_next  = SUM_W'(bias_reg) + term;
                        area_next = ATOT_W'(parea_reg[0]) + ATOT_W'(parea_reg[1]);
                    end
                    else
                    begin
                        sum_next  = sum_reg + term;
                        area_next = area_reg + ATOT_W'(parea_reg[slot_a]) +
                                    ATOT_W'(parea_reg[slot_a + 3'd1]);
                    end
                    if (comp_reg == COMP_W)
                        state_next = S_CHECK;
                    else
                    begin
                        phase_next = comp_reg + 2'd1;
                        state_next = S_IDLE;
                    end
                end
            end
            S_CHECK:
            begin
                phase_next = 2'd0;
                if (area_reg == '0)
                begin
                    done_next       = 1'b1;
                    read_value_next = '0;
                    status_next     = ST_AREA;
                    state_next      = S_IDLE;
                end
                else if (pdiv_reg[0] == '0 || pdiv_reg[1] == '0 || pdiv_reg[2] == '0)
                begin
                    done_next       = 1'b1;
                    read_value_next = '0;
                    status_next     = ST_DIV;
                    state_next      = S_IDLE;
                end
                else
                begin
                    // Quotient of the divergence scaled by 2^16 over the area sum.
                    div_start   = 1'b1;
                    div_num     = DIV_N_W'({sum_mag, 16'h0000});
                    div_den     = area_reg;
                    dv_neg_next = sum_reg[SUM_W-1];
                    state_next  = S_DV_DIV;
                end
            end
            S_DV_DIV:
            begin
                if (div_done)
                begin
                    dv_neg_next = dv[VAL_W-1];
                    dv_mag_next = dv[VAL_W-1] ? (32'd0 - dv) : dv;
                    k_next      = '0;
                    state_next  = S_SH_START;
                end
            end
            S_SH_START:
            begin
                if (k_reg == 3'd6)
                begin
                    done_next       = 1'b1;
                    read_value_next = '0;
                    status_next     = ST_OK;
                    state_next      = S_IDLE;
                end
                else if (!cell_ok(pidx_reg[k_reg]))
                    k_next = k_reg + 3'd1;
                else
                begin
                    mul_start  = 1'b1;
                    mul_a      = parea_reg[k_reg];
                    mul_b      = MUL_B_W'(dv_mag_reg);
                    state_next = S_SH_MUL;
                end
            end
            S_SH_MUL:
            begin
                if (mul_done)
                begin
                    div_start  = 1'b1;
                    div_num    = DIV_N_W'(mul_product);
                    div_den    = DIV_D_W'(pdiv_reg[k_reg[2:1]]);
                    state_next = S_SH_DIV;
                end
            end
            S_SH_DIV:
            begin
                if (div_done)
                begin
                    share_next = sat_mag(dv_neg_reg, div_quot);
                    state_next = S_SH_RD;
                end
            end
            S_SH_RD:
            begin
                mem_raddr  = cell_addr(pidx_reg[k_reg]);
                state_next = S_SH_WR;
            end
            S_SH_WR:
            begin
                rsel       = k_reg[2:1];
                mem_we     = 1'b1;
                mem_wsel   = k_reg[2:1];
                mem_waddr  = cell_addr(pidx_reg[k_reg]);
                mem_wdata  = nv_sat;
                k_next     = k_reg + 3'd1;
                state_next = S_SH_START;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (state_reg == S_AX_RB || state_reg == S_AX_DIFF)
            rsel = comp_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            phase_reg  <= 2'd0;
            done_reg   <= 1'b0;
            status_reg <= ST_OK;
            k_reg      <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            phase_reg  <= phase_next;
            done_reg   <= done_next;
            status_reg <= status_next;
            k_reg      <= k_next;
        end
    end

    always_ff @(posedge clk)
    begin
        comp_reg       <= comp_next;
        rd_ok_reg      <= rd_ok_next;
        bias_reg       <= bias_next;
        pidx_reg       <= pidx_next;
        parea_reg      <= parea_next;
        pdiv_reg       <= pdiv_next;
        va_reg         <= va_next;
        diff_neg_reg   <= diff_neg_next;
        sum_reg        <= sum_next;
        area_reg       <= area_next;
        dv_neg_reg     <= dv_neg_next;
        dv_mag_reg     <= dv_mag_next;
        share_reg      <= share_next;
        read_value_reg <= read_value_next;
    end

    assign busy       = (state_reg != S_IDLE);
    assign done       = done_reg;
    assign read_value = read_value_reg;
    assign status     = status_reg;

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while a request is still in progress");

    a_read_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && operation == OP_READ) |=> busy ##1 (done && status == ST_OK))
        else $error("read result not delivered two cycles after the request");

    a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg != 2'd3)
        else $error("axis phase left the x, y, z sequence");

    a_stencil_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status != ST_OK) |-> (read_value == '0))
        else $error("error status with a nonzero read value");

endmodule
